### rtl/iaids_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed array store: field widths, command and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package iaids_pkg;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 9;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int FOUND_W    = 8;
  localparam int LEN_W      = 9;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_PLACE,
    S_DN,
    S_SRCH,
    S_CLR
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_TOP,
    IDX_LOAD_NEXT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_LOAD
  } cnt_op_t;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_IDX_UP,
    WA_IDX_DN,
    WA_POS
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_RDATA,
    WD_VAL,
    WD_ZERO
  } wd_sel_t;

  typedef struct packed {
    logic    ld_item;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    mem_we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    res_load;
    status_t res_status;
    logic    res_found;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_full;
    logic             pos_lt_cnt;
    logic             pos_eq_cnt;
    logic             pos_gt_cnt;
    logic             pos_p1_lt_cnt;
    logic             idx_gt_pos;
    logic             idx_p1_lt_cnt;
    logic             idx_p1_lt_len;
    logic             len_zero;
    logic             match;
  } dp_stat_t;

endpackage

### rtl/iaids_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iaids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/iaids_dp.sv
`timescale 1ns / 1ps
// Datapath of the indexed array store: item and config registers, length, walk index,
// entry RAM, comparators and result register. Uses iaids_pkg and iaids_ram.
module iaids_dp import iaids_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int PAD = OUT_DATA_W - LEN_W - FOUND_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  logic [LEN_W-1:0]   start_len_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [POS_W-1:0]   pos_r;
  logic [VAL_W-1:0]   val_r;
  logic [AW-1:0]      idx_r, idx_nxt;
  status_t            status_r;
  logic [FOUND_W-1:0] found_r;
  logic [LEN_W-1:0]   length_r;

  logic [CW-1:0]    clr_len;
  logic [XW-1:0]    cnt_x, pos_x, idx_x, len_x, start_x;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata, rdata;

  assign start_x = XW'(start_len_r);
  assign clr_len = (start_x > CAP_X) ? CAP_C : CW'(start_len_r);
  assign cnt_x   = XW'(count_r);
  assign pos_x   = XW'(pos_r);
  assign idx_x   = XW'(idx_r);
  assign len_x   = XW'(clr_len);

  always_comb begin
    case (cmd.idx_op)
      IDX_LOAD_TOP:  idx_nxt = AW'(count_r - 1'b1);
      IDX_LOAD_NEXT: idx_nxt = AW'(pos_r + 1'b1);
      IDX_ZERO:      idx_nxt = '0;
      IDX_INC:       idx_nxt = idx_r + 1'b1;
      IDX_DEC:       idx_nxt = idx_r - 1'b1;
      default:       idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC:  count_nxt = count_r + 1'b1;
      CNT_DEC:  count_nxt = count_r - 1'b1;
      CNT_LOAD: count_nxt = clr_len;
      default:  count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      WA_IDX_UP: waddr = idx_r + 1'b1;
      WA_IDX_DN: waddr = idx_r - 1'b1;
      WA_POS:    waddr = AW'(pos_r);
      default:   waddr = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_VAL:  wdata = val_r;
      WD_ZERO: wdata = '0;
      default: wdata = rdata;
    endcase
  end

  iaids_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_nxt),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        start_len_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.ld_item) begin
      cmd_r <= in_tuser[CMD_W-1:0];
      pos_r <= in_tdata[POS_W-1:0];
      val_r <= in_tdata[POS_W +: VAL_W];
    end
    if (cmd.res_load) begin
      status_r <= cmd.res_status;
      found_r  <= cmd.res_found ? FOUND_W'(idx_r) : '0;
      length_r <= LEN_W'(count_nxt);
    end
  end

  always_comb begin
    stat.cmd           = cmd_r;
    stat.cnt_zero      = (count_r == '0);
    stat.cnt_full      = (cnt_x >= CAP_X);
    stat.pos_lt_cnt    = (pos_x < cnt_x);
    stat.pos_eq_cnt    = (pos_x == cnt_x);
    stat.pos_gt_cnt    = (pos_x > cnt_x);
    stat.pos_p1_lt_cnt = ((pos_x + XW'(1)) < cnt_x);
    stat.idx_gt_pos    = (idx_x > pos_x);
    stat.idx_p1_lt_cnt = ((idx_x + XW'(1)) < cnt_x);
    stat.idx_p1_lt_len = ((idx_x + XW'(1)) < len_x);
    stat.len_zero      = (clr_len == '0);
    stat.match         = (rdata == val_r);
  end

  assign out_tdata = {{PAD{1'b0}}, length_r, found_r};
  assign out_tuser = status_r;

endmodule

### rtl/iaids_ctrl.sv
`timescale 1ns / 1ps
// Controller of the indexed array store: command decode and the walk sequencer,
// plus the result valid flag. Uses iaids_pkg.
module iaids_ctrl import iaids_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.ld_item    = 1'b0;
    cmd.idx_op     = IDX_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.mem_we     = 1'b0;
    cmd.wa_sel     = WA_IDX;
    cmd.wd_sel     = WD_RDATA;
    cmd.res_load   = 1'b0;
    cmd.res_status = ST_OK;
    cmd.res_found  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt    = S_IDLE;
        cmd.res_load = 1'b1;
        unique case (stat.cmd)
          CMD_WRITE: begin
            if (stat.pos_lt_cnt) begin
              cmd.mem_we = 1'b1;
              cmd.wa_sel = WA_POS;
              cmd.wd_sel = WD_VAL;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          CMD_INSERT: begin
            if (stat.pos_gt_cnt) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.cnt_full) begin
              cmd.res_status = ST_FULL;
            end else if (stat.pos_eq_cnt) begin
              cmd.res_load = 1'b0;
              state_nxt    = S_PLACE;
            end else begin
              cmd.res_load = 1'b0;
              cmd.idx_op   = IDX_LOAD_TOP;
              state_nxt    = S_UP;
            end
          end
          CMD_DELETE: begin
            if (stat.cnt_zero) begin
              cmd.res_status = ST_EMPTY;
            end else if (!stat.pos_lt_cnt) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.pos_p1_lt_cnt) begin
              cmd.res_load = 1'b0;
              cmd.idx_op   = IDX_LOAD_NEXT;
              state_nxt    = S_DN;
            end else begin
              cmd.cnt_op = CNT_DEC;
            end
          end
          CMD_SEARCH: begin
            if (stat.cnt_zero) begin
              cmd.res_status = ST_NOTFOUND;
            end else begin
              cmd.res_load = 1'b0;
              cmd.idx_op   = IDX_ZERO;
              state_nxt    = S_SRCH;
            end
          end
          CMD_CLEAR: begin
            if (stat.len_zero) begin
              cmd.cnt_op = CNT_LOAD;
            end else begin
              cmd.res_load = 1'b0;
              cmd.idx_op   = IDX_ZERO;
              state_nxt    = S_CLR;
            end
          end
          default: begin
          end
        endcase
      end
      S_UP: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = WA_IDX_UP;
        cmd.wd_sel = WD_RDATA;
        if (stat.idx_gt_pos) begin
          cmd.idx_op = IDX_DEC;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.mem_we   = 1'b1;
        cmd.wa_sel   = WA_POS;
        cmd.wd_sel   = WD_VAL;
        cmd.cnt_op   = CNT_INC;
        cmd.res_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DN: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = WA_IDX_DN;
        cmd.wd_sel = WD_RDATA;
        if (stat.idx_p1_lt_cnt) begin
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.cnt_op   = CNT_DEC;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SRCH: begin
        if (stat.match) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.idx_p1_lt_cnt) begin
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = WA_IDX;
        cmd.wd_sel = WD_ZERO;
        if (stat.idx_p1_lt_len) begin
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.cnt_op   = CNT_LOAD;
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.res_load || (out_valid_r && !out_tready);
  end

endmodule

### rtl/indexed_array_insert_delete_search.sv
`timescale 1ns / 1ps
// Indexed array store, top level: joins controller and datapath, holds the assertions.
// Uses iaids_pkg, iaids_ctrl and iaids_dp.
//
// Ordered store of up to CAPACITY signed 32-bit values with a current length. Each input
// beat carries one command (write, insert, delete, search, clear) and yields exactly one
// result beat with status, first match index and the length after the command. One item
// is in work at a time; the entries live in a single-port-write RAM that is walked one
// entry per cycle. Write, rejected commands and unknown codes finish in the execute
// state; insert walks down from the top entry to position p, delete walks up from p + 1,
// search walks from entry 0 to the first match or the end, and clear zeroes from entry 0
// up to start_length, capped at CAPACITY. The next beat is taken once the result register
// is free or being drained in that cycle. No clearing pass follows reset: the length
// starts at zero and clear zeroes every entry it makes valid.
module indexed_array_insert_delete_search import iaids_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data,  // start_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,     // position[8:0], value[40:9], zero pad
  input  logic [IN_USER_W-1:0]  in_tuser,     // command[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // found_position[7:0], length[16:8], zero pad
  output logic [OUT_USER_W-1:0] out_tuser     // status[2:0]
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  iaids_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  iaids_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.res_load |-> (!out_tvalid || out_tready))
    else $error("result overwrites an undelivered beat");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[FOUND_W +: LEN_W]) <= CAPACITY))
    else $error("reported length above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !dp_cmd.mem_we)
    else $error("entry write while idle");

endmodule
